@@ hdl/lpft_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpft_pkg
// Shared types and constants for the LRU page frame table: port widths,
// reset values, the cell control bundle and the sequencer state encoding.
// ----------------------------------------------------------------------------
package lpft_pkg;

  // default sizing
  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 20;

  // fixed port widths
  localparam int PAGE_W  = 20;
  localparam int FRAME_W = 4;
  localparam int TOTAL_W = 32;
  localparam int LIMIT_W = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  // control broadcast to every cell of the row
  typedef struct packed {
    logic compare;  // compare stored tag with the looked-up page
    logic update;   // shift the recency stack toward the tail
  } cell_ctl_t;

  // request sequencer
  typedef enum logic [1:0] {
    ST_IDLE    = 2'b01,
    ST_RESOLVE = 2'b10
  } state_t;

endpackage

@@ hdl/lru_page_frame_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_frame_table_unit
// Fully associative page frame table with LRU replacement, built as a row
// of cells forming a recency stack.
//
//   channel  ports                                   handshake
//   -------  --------------------------------------  ----------------------
//   request  in_op, in_virtual_page, in_tlb_hit      start & !busy
//   result   out_frame .. out_dirty_eviction_total   out_strobe, one cycle
//   config   cfg_data                                cfg_we
//
// A request has an accept cycle, which compares the page against every
// cell, and a resolve cycle, which gathers the hit or victim entry and
// shifts the stack. busy is high in the resolve cycle and blocks start.
// The result strobe is high in the cycle after resolve; the receiver cannot
// stall it. Synchronous reset empties the table and sets the limit to 16;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_page_frame_table_unit
  import lpft_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic [PAGE_W-1:0]  in_virtual_page,
  input  logic               in_tlb_hit,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_data,
  output logic               out_strobe,
  output logic [FRAME_W-1:0] out_frame,
  output logic               out_page_hit,
  output logic               out_evict_valid,
  output logic [PAGE_W-1:0]  out_evict_page,
  output logic               out_evict_dirty,
  output logic [TOTAL_W-1:0] out_read_total,
  output logic [TOTAL_W-1:0] out_write_total,
  output logic [TOTAL_W-1:0] out_dirty_eviction_total
);

  localparam int TAG_W = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
  localparam int IDX_W = $clog2(FRAMES);
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam logic [CMP_W-1:0] FRAMES_C = CMP_W'(FRAMES);

  state_t             state_r, state_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic [CNT_W-1:0]   assigned_r;
  logic               req_wr_r;
  logic               req_tlb_r;
  logic [TAG_W-1:0]   req_page_r;
  logic [TOTAL_W-1:0] read_cnt_r, write_cnt_r, dirty_cnt_r;
  logic               accept;
  cell_ctl_t          ctl;

  // cell row signals
  logic [TAG_W-1:0] c_tag   [FRAMES];
  logic [IDX_W-1:0] c_frame [FRAMES];
  logic [FRAMES-1:0] c_dirty, c_valid, c_match, c_last;
  logic [TAG_W-1:0] p_tag   [FRAMES];
  logic [IDX_W-1:0] p_frame [FRAMES];
  logic [FRAMES-1:0] p_dirty, p_valid;

  // gathered entries
  logic             hit_any;
  logic [IDX_W-1:0] hit_pos, hit_frame, vic_frame;
  logic             hit_dirty, vic_dirty;
  logic [TAG_W-1:0] vic_tag;

  // resolve decisions
  logic [CMP_W-1:0] lim_ext, lim_eff;
  logic             has_free;
  logic [IDX_W-1:0] last_pos, shift_pos, sel_frame;
  logic             head_dirty, evict, evict_dirty;

  assign accept = start && !busy;
  assign busy   = (state_r == ST_RESOLVE);
  assign ctl.compare = accept;
  assign ctl.update  = (state_r == ST_RESOLVE);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (accept) state_nxt = ST_RESOLVE;
      ST_RESOLVE: state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // frame limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_data;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_wr_r   <= in_op;
      req_tlb_r  <= in_tlb_hit;
      req_page_r <= in_virtual_page[TAG_W-1:0];
    end
  end

  // cell row: slot 0 takes the head entry, the rest take their neighbor
  genvar gi;
  generate
    for (gi = 0; gi < FRAMES; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign p_tag[gi]   = req_page_r;
        assign p_frame[gi] = sel_frame;
        assign p_dirty[gi] = head_dirty;
        assign p_valid[gi] = 1'b1;
      end else begin : g_link
        assign p_tag[gi]   = c_tag[gi-1];
        assign p_frame[gi] = c_frame[gi-1];
        assign p_dirty[gi] = c_dirty[gi-1];
        assign p_valid[gi] = c_valid[gi-1];
      end

      lpft_cell #(
        .TAG_W (TAG_W),
        .IDX_W (IDX_W),
        .INDEX (gi)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .lookup_page (in_virtual_page[TAG_W-1:0]),
        .last_pos    (last_pos),
        .shift_pos   (shift_pos),
        .prev_tag    (p_tag[gi]),
        .prev_frame  (p_frame[gi]),
        .prev_dirty  (p_dirty[gi]),
        .prev_valid  (p_valid[gi]),
        .tag_r       (c_tag[gi]),
        .frame_r     (c_frame[gi]),
        .dirty_r     (c_dirty[gi]),
        .valid_r     (c_valid[gi]),
        .match_r     (c_match[gi]),
        .last_r      (c_last[gi])
      );
    end
  endgenerate

  // one-hot gather of the hit slot and the tail slot
  always_comb begin
    hit_pos   = '0;
    hit_frame = '0;
    hit_dirty = 1'b0;
    vic_frame = '0;
    vic_dirty = 1'b0;
    vic_tag   = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (c_match[i]) begin
        hit_pos   = hit_pos | IDX_W'(i);
        hit_frame = hit_frame | c_frame[i];
        hit_dirty = hit_dirty | c_dirty[i];
      end
      if (c_last[i]) begin
        vic_frame = vic_frame | c_frame[i];
        vic_dirty = vic_dirty | c_dirty[i];
        vic_tag   = vic_tag | c_tag[i];
      end
    end
  end
  assign hit_any = |c_match;

  // effective limit, clamped to one .. FRAMES
  always_comb begin
    lim_ext = CMP_W'(limit_r);
    lim_eff = lim_ext;
    if (lim_ext == '0) lim_eff = CMP_W'(1);
    if (lim_ext > FRAMES_C) lim_eff = FRAMES_C;
  end
  assign has_free = (CMP_W'(assigned_r) < lim_eff);
  assign last_pos = IDX_W'(assigned_r - CNT_W'(1));

  // hit, free frame or eviction of the tail
  always_comb begin
    evict       = 1'b0;
    evict_dirty = 1'b0;
    if (hit_any) begin
      sel_frame  = hit_frame;
      shift_pos  = hit_pos;
      head_dirty = hit_dirty | req_wr_r;
    end else if (has_free) begin
      sel_frame  = IDX_W'(assigned_r);
      shift_pos  = IDX_W'(assigned_r);
      head_dirty = req_wr_r;
    end else begin
      sel_frame   = vic_frame;
      shift_pos   = last_pos;
      head_dirty  = req_wr_r;
      evict       = 1'b1;
      evict_dirty = vic_dirty;
    end
  end

  // fill count and access counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      assigned_r  <= '0;
      read_cnt_r  <= '0;
      write_cnt_r <= '0;
      dirty_cnt_r <= '0;
    end else if (state_r == ST_RESOLVE) begin
      if (!hit_any && has_free) assigned_r <= assigned_r + CNT_W'(1);
      read_cnt_r  <= read_cnt_r + TOTAL_W'(!req_tlb_r) + TOTAL_W'(!hit_any);
      write_cnt_r <= write_cnt_r + TOTAL_W'(req_wr_r);
      dirty_cnt_r <= dirty_cnt_r + TOTAL_W'(evict_dirty);
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= (state_r == ST_RESOLVE);
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state_r == ST_RESOLVE) begin
      out_frame       <= FRAME_W'(sel_frame);
      out_page_hit    <= hit_any;
      out_evict_valid <= evict;
      out_evict_page  <= evict ? PAGE_W'(vic_tag) : '0;
      out_evict_dirty <= evict_dirty;
    end
  end

  assign out_read_total           = read_cnt_r;
  assign out_write_total          = write_cnt_r;
  assign out_dirty_eviction_total = dirty_cnt_r;

  // checks
  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held for more than one cycle");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_strobe)
    else $error("no result two cycles after an accepted request");

  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESOLVE) |-> $onehot0(c_match))
    else $error("page resident in more than one slot");

  a_fill_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(c_valid) == int'(assigned_r))
    else $error("valid slots disagree with fill count");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(assigned_r) <= FRAMES)
    else $error("fill count beyond frame count");

endmodule

@@ hdl/lpft_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpft_cell
// One slot of the recency stack. Slot position is the LRU rank (slot 0 is
// most recent). Holds a page tag, its frame number and dirty mark, compares
// the tag on lookup and takes its neighbor's entry when the stack shifts.
// ----------------------------------------------------------------------------
module lpft_cell
  import lpft_pkg::*;
#(
  parameter int TAG_W = PAGE_BITS_DEF,
  parameter int IDX_W = 4,
  parameter int INDEX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cell_ctl_t        ctl,
  input  logic [TAG_W-1:0] lookup_page,
  input  logic [IDX_W-1:0] last_pos,
  input  logic [IDX_W-1:0] shift_pos,
  input  logic [TAG_W-1:0] prev_tag,
  input  logic [IDX_W-1:0] prev_frame,
  input  logic             prev_dirty,
  input  logic             prev_valid,
  output logic [TAG_W-1:0] tag_r,
  output logic [IDX_W-1:0] frame_r,
  output logic             dirty_r,
  output logic             valid_r,
  output logic             match_r,
  output logic             last_r
);

  localparam logic [IDX_W-1:0] MY_POS = IDX_W'(INDEX);

  logic shift_en;

  // every slot from the head to the touched position moves one step toward the tail
  assign shift_en = ctl.update && (MY_POS <= shift_pos);

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      if (ctl.compare) begin
        match_r <= valid_r && (tag_r == lookup_page);
        last_r  <= (MY_POS == last_pos);
      end
      if (shift_en) begin
        valid_r <= prev_valid;
      end
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (shift_en) begin
      tag_r   <= prev_tag;
      frame_r <= prev_frame;
      dirty_r <= prev_dirty;
    end
  end

endmodule
